// ===== sv/swpc_pkg.sv =====
package swpc_pkg;

    // Ring geometry
    localparam int MAX_PANES = 16;
    localparam int PANE_IDX_W = (MAX_PANES > 1) ? $clog2(MAX_PANES) : 1;
    localparam int PANE_CNT_W = $clog2(MAX_PANES + 1);

    // Word field widths
    localparam int STAMP_W = 32;
    localparam int AMOUNT_W = 16;
    localparam int COUNT_W = 32;
    localparam int CFG_W = 5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MATCH,
        S_UPDATE,
        S_SUM,
        S_DONE
    } t_state;

endpackage

// ===== sv/sliding_window_pane_counter.sv =====
// Sliding-window pane counter. A ring of panes, each a time stamp and an event
// count. A word is taken on start while busy is low: if a pane in use holds the
// stamp, its count grows by the amount (saturating at 32 bits), else the next ring
// slot is overwritten with the stamp and the amount. One result word follows per
// input word: the saturating sum of all pane counts in use, shown on
// o_window_total for exactly one cycle with o_result_valid; the receiver cannot
// stall it, so it must take it in that cycle. All work runs through one shared
// compare and one shared 33-bit saturating adder under a small sequencer: a match
// scan up to the first matching pane (all n panes on a miss), an update step, a
// sum scan over all n panes and a result step, n being the panes in use. busy is
// high from the match scan through the result step, so a new word is taken only
// once the last one is through. Pane state clears on reset; no clearing pass.
// panes_in_use (reset 16, zero counts as one, above the ring size counts as the
// ring size) is written through i_cfg_we / i_cfg_wdata; the user must write it
// only while idle, the block itself does not enforce this.
module sliding_window_pane_counter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [swpc_pkg::STAMP_W-1:0]  i_time_stamp,
    input  logic [swpc_pkg::AMOUNT_W-1:0] i_amount,
    output logic                          o_result_valid,
    output logic [swpc_pkg::COUNT_W-1:0]  o_window_total,
    input  logic                          i_cfg_we,
    input  logic [swpc_pkg::CFG_W-1:0]    i_cfg_wdata
);
    import swpc_pkg::*;

    t_state r_state, n_state;

    logic [CFG_W-1:0]      r_cfg;
    logic [STAMP_W-1:0]    r_pane_stamp [MAX_PANES];
    logic [COUNT_W-1:0]    r_pane_count [MAX_PANES];
    logic [PANE_IDX_W-1:0] r_next_slot;
    logic [PANE_IDX_W-1:0] r_idx;
    logic                  r_hit;
    logic [STAMP_W-1:0]    r_stamp;
    logic [AMOUNT_W-1:0]   r_amount;
    logic [COUNT_W-1:0]    r_total;

    // Panes in use, clamped to 1..MAX_PANES
    logic [PANE_CNT_W-1:0] n_act;
    logic [PANE_IDX_W-1:0] last_idx;
    logic                  accept;
    logic                  stamp_eq;
    logic                  at_last;

    // Shared saturating adder
    logic [COUNT_W-1:0] add_a, add_b, add_sat;
    logic [COUNT_W:0]   add_sum;

    // Miss placement
    logic [PANE_IDX_W-1:0] slot;
    logic [PANE_CNT_W-1:0] slot_inc;

    always_comb begin
        if (r_cfg == '0) begin
            n_act = PANE_CNT_W'(1);
        end else if (int'(r_cfg) > MAX_PANES) begin
            n_act = PANE_CNT_W'(MAX_PANES);
        end else begin
            n_act = PANE_CNT_W'(r_cfg);
        end
    end

    assign last_idx = PANE_IDX_W'(n_act - PANE_CNT_W'(1));
    assign accept   = start && !busy;
    assign stamp_eq = (r_pane_stamp[r_idx] == r_stamp);
    assign at_last  = (r_idx == last_idx);

    // Operand select: pane update in S_UPDATE, running total otherwise
    always_comb begin
        add_a = r_total;
        add_b = r_pane_count[r_idx];
        if (r_state == S_UPDATE) begin
            add_a = r_pane_count[r_idx];
            add_b = COUNT_W'(r_amount);
        end
    end

    assign add_sum = {1'b0, add_a} + {1'b0, add_b};
    assign add_sat = add_sum[COUNT_W] ? '1 : add_sum[COUNT_W-1:0];

    // Shrunk ring: stale next slot falls back to slot zero
    assign slot     = (PANE_CNT_W'(r_next_slot) < n_act) ? r_next_slot : '0;
    assign slot_inc = PANE_CNT_W'(slot) + PANE_CNT_W'(1);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (start) begin
                n_state = S_MATCH;
            end
            S_MATCH:  if (stamp_eq || at_last) begin
                n_state = S_UPDATE;
            end
            S_UPDATE: n_state = S_SUM;
            S_SUM:    if (at_last) begin
                n_state = S_DONE;
            end
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        busy           = 1'b1;
        o_result_valid = 1'b0;
        unique case (r_state)
            S_IDLE:  busy = 1'b0;
            S_DONE:  o_result_valid = 1'b1;
            default: busy = 1'b1;
        endcase
    end

    assign o_window_total = r_total;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cfg       <= CFG_W'(16);
            r_next_slot <= '0;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            for (int i = 0; i < MAX_PANES; i++) begin
                r_pane_stamp[i] <= '0;
                r_pane_count[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_idx <= '0;
                    r_hit <= 1'b0;
                end
                S_MATCH: begin
                    // index holds on a hit so S_UPDATE reads the matching pane
                    if (stamp_eq) begin
                        r_hit <= 1'b1;
                    end else if (!at_last) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_UPDATE: begin
                    if (r_hit) begin
                        r_pane_count[r_idx] <= add_sat;
                    end else begin
                        r_pane_stamp[slot] <= r_stamp;
                        r_pane_count[slot] <= COUNT_W'(r_amount);
                        r_next_slot <= (slot_inc >= n_act) ? '0 : PANE_IDX_W'(slot_inc);
                    end
                    r_idx <= '0;
                end
                S_SUM: begin
                    if (!at_last) begin
                        r_idx <= r_idx + 1'b1;
                    end
                end
                S_DONE: r_idx <= '0;
                default: r_idx <= '0;
            endcase
        end
    end

    // Word capture and running total
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_stamp  <= i_time_stamp;
            r_amount <= i_amount;
        end
        if (r_state == S_UPDATE) begin
            r_total <= '0;
        end else if (r_state == S_SUM) begin
            r_total <= add_sat;
        end
    end

`ifndef SYNTHESIS
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MATCH || r_state == S_SUM) |-> (r_idx <= last_idx))
        else $error("scan index beyond panes in use");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (busy && r_state == S_MATCH))
        else $error("accepted word did not start a match scan");

    a_result_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |=> (!busy && !o_result_valid))
        else $error("result strobe not followed by idle");

    a_result_after_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result_valid |-> ($past(r_state) == S_SUM))
        else $error("result strobe without a completed sum scan");

    a_hit_is_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE && r_hit) |-> (r_pane_stamp[r_idx] == r_stamp))
        else $error("update hit on a pane that does not hold the stamp");
`endif

endmodule

// ===== tb/tb_sliding_window_pane_counter.sv =====
module tb_sliding_window_pane_counter;
    timeunit 1ns;
    timeprecision 1ps;

    import swpc_pkg::*;

    // Timing
    localparam int CLK_PERIOD   = 10;
    localparam int RESET_CYCLES = 7;
    // Slowest correct run: under 1900 words, each a full busy stretch plus an idle
    // gap; the watchdog sits several times above that.
    localparam int CYCLE_LIMIT  = 500_000;
    // Longest word: full match scan, update, full sum scan and result step.
    localparam int TAIL_CYCLES  = 2 * MAX_PANES + 8;
    localparam int REPORT_MAX   = 10;
    localparam int RANDOM_WORDS = 1680;
    // Full-scale words heaped onto one pane, carrying its count well past 16 bits
    localparam int PUMP_WORDS   = 40;

    localparam logic [AMOUNT_W-1:0] AMOUNT_MAX = '1;
    localparam logic [STAMP_W-1:0]  STAMP_MAX  = '1;

    // DUT ports; every input known from time zero
    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                start          = 1'b0;
    logic                busy;
    logic [STAMP_W-1:0]  i_time_stamp   = '0;
    logic [AMOUNT_W-1:0] i_amount       = '0;
    logic                o_result_valid;
    logic [COUNT_W-1:0]  o_window_total;
    logic                i_cfg_we       = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wdata    = '0;

    // Predictor state: our own copy of the pane ring and the limit register
    logic [STAMP_W-1:0]  ring_stamp [MAX_PANES];
    logic [COUNT_W-1:0]  ring_count [MAX_PANES];
    int unsigned         ring_next;
    logic [CFG_W-1:0]    pane_limit_reg;

    // Totals still owed by the block, oldest first
    logic [COUNT_W-1:0]  totals_due [$];
    logic [COUNT_W-1:0]  total_now;

    // Sender bookkeeping
    bit                  sender_gaps = 1'b1;  // draw idle gaps between words
    int unsigned         gap_next    = 0;     // gap before the next word
    bit                  start_high  = 1'b0;  // mirror of start as last driven
    int unsigned         words_sent  = 0;

    int unsigned         fail_count  = 0;
    int unsigned         cycle_count = 0;

    sliding_window_pane_counter u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_time_stamp   (i_time_stamp),
        .i_amount       (i_amount),
        .o_result_valid (o_result_valid),
        .o_window_total (o_window_total),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata)
    );

    initial begin
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    // Watchdog: a hang anywhere ends the run as a failure
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [COUNT_W-1:0] add_clamped(input logic [COUNT_W-1:0] a,
                                                       input logic [COUNT_W-1:0] b);
        logic [COUNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[COUNT_W] ? {COUNT_W{1'b1}} : s[COUNT_W-1:0];
    endfunction

    // Zero in the register means one pane, anything past the ring means all.
    function automatic int unsigned live_panes();
        if (pane_limit_reg == 0)
            return 1;
        if (pane_limit_reg > MAX_PANES)
            return MAX_PANES;
        return int'(pane_limit_reg);
    endfunction

    function automatic void clear_ring();
        for (int i = 0; i < MAX_PANES; i++) begin
            ring_stamp[i] = '0;
            ring_count[i] = '0;
        end
        ring_next      = 0;
        pane_limit_reg = CFG_W'(MAX_PANES);
    endfunction

    // Apply one accepted word to the ring and queue the window total it yields.
    function automatic void predict_window_total(input logic [STAMP_W-1:0]  stamp,
                                                 input logic [AMOUNT_W-1:0] amt);
        int unsigned n;
        int          hit;
        int unsigned slot;
        logic [COUNT_W-1:0] sum;
        n   = live_panes();
        hit = -1;
        // lowest matching pane in use wins; panes past n are invisible
        for (int i = 0; i < n; i++) begin
            if (hit < 0 && ring_stamp[i] == stamp)
                hit = i;
        end
        if (hit >= 0) begin
            ring_count[hit] = add_clamped(ring_count[hit], COUNT_W'(amt));
        end else begin
            // ring shrunk under the pointer: restart at slot zero
            slot             = (ring_next < n) ? ring_next : 0;
            ring_stamp[slot] = stamp;
            ring_count[slot] = COUNT_W'(amt);
            ring_next        = (slot + 1 >= n) ? 0 : slot + 1;
        end
        sum = '0;
        for (int i = 0; i < n; i++)
            sum = add_clamped(sum, ring_count[i]);
        totals_due.push_back(sum);
    endfunction

    // ------------------------------------------------------------------
    // Result checker: every strobed total is taken in its one cycle
    // ------------------------------------------------------------------

    function automatic void note_failure(input string what);
        fail_count++;
        if (fail_count <= REPORT_MAX)
            $display("[%0t] mismatch: %s", $realtime, what);
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && o_result_valid) begin
            if (totals_due.size() == 0) begin
                note_failure($sformatf("total %h with no word outstanding", o_window_total));
            end else begin
                total_now = totals_due.pop_front();
                if (o_window_total !== total_now)
                    note_failure($sformatf("window_total expected %h actual %h",
                                           total_now, o_window_total));
            end
        end
    end

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // One word: optional idle gap, then hold start until the block takes it.
    // start is only dropped after acceptance when a gap follows; a back-to-back
    // word keeps it high so it is never lowered and raised in one step.
    task automatic send_word(input logic [STAMP_W-1:0]  stamp,
                             input logic [AMOUNT_W-1:0] amt);
        if (gap_next > 0)
            repeat (gap_next) @(posedge i_clk);
        start        <= 1'b1;
        start_high    = 1'b1;
        i_time_stamp <= stamp;
        i_amount     <= amt;
        do @(posedge i_clk); while (busy);
        predict_window_total(stamp, amt);
        words_sent++;
        gap_next = sender_gaps ? $urandom_range(0, 9) : 0;
        if (gap_next > 0) begin
            start     <= 1'b0;
            start_high = 1'b0;
        end
    endtask

    // Drop start, then hold off until every owed total has been seen.
    task automatic wait_idle();
        if (start_high) begin
            start     <= 1'b0;
            start_high = 1'b0;
        end
        do @(posedge i_clk); while (totals_due.size() != 0);
    endtask

    // Register write, only ever with the block idle
    task automatic write_pane_limit(input logic [CFG_W-1:0] value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we      <= 1'b0;
        pane_limit_reg = value;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Straight out of reset, sixteen panes all stamped zero: a zero stamp
    // lands on pane 0, and once pane 0 moves on the next zero pane catches it.
    task automatic test_reset_panes();
        send_word('0, 16'h0001);
        send_word('0, AMOUNT_MAX);
        send_word(STAMP_MAX, AMOUNT_MAX);   // miss, overwrites slot 0
        send_word('0, '0);                  // now pane 1 is the lowest zero
        send_word(32'h5555_AAAA, 16'h8000);
    endtask

    // Three-pane ring: fill, wrap, hit the survivor, miss the evicted one.
    // The pointer left by the previous test sits at slot two, inside the ring.
    task automatic test_ring_wrap();
        write_pane_limit(CFG_W'(3));
        send_word(32'h0000_1000, 16'h0011);
        send_word(32'h0000_1001, 16'h0022);
        send_word(32'h0000_1002, 16'h0033);
        send_word(32'h0000_1003, 16'h0044);
        send_word(32'h0000_1004, 16'h0055);
        send_word(32'h0000_1004, 16'h7FFF);
        send_word(32'h0000_1000, 16'h0001);
    endtask

    // Five panes written into an eight-pane ring, ring cut to two (pointer now beyond the ring), then
    // grown again: the panes outside the cut keep their stamps and counts.
    task automatic test_ring_shrink();
        write_pane_limit(CFG_W'(8));
        for (int i = 0; i < 5; i++)
            send_word(32'hC0DE_0000 + i, AMOUNT_W'(16'h0100 * (i + 1)));
        write_pane_limit(CFG_W'(2));
        send_word(32'hC0DE_0100, 16'h0009);
        send_word(32'hC0DE_0004, 16'h0003);  // held beyond the ring, so a miss
        write_pane_limit(CFG_W'(MAX_PANES));
        send_word(32'hC0DE_0003, 16'h0002);  // hidden pane comes back intact
    endtask

    // Out-of-range register values: zero acts as one, 17..31 as sixteen.
    task automatic test_register_limits();
        write_pane_limit('0);
        send_word(32'hBEEF_0001, 16'h00F0);
        send_word(32'hBEEF_0002, 16'h0F00);
        write_pane_limit('1);
        send_word(32'hBEEF_0003, 16'hF000);
        write_pane_limit(CFG_W'(MAX_PANES + 1));
        send_word(32'hBEEF_0001, 16'h000F);
    endtask

    // Heap full-scale amounts onto one pane of a one-pane ring, back to back,
    // then widen to two so the total adds a live pane onto the large one.
    task automatic test_count_saturation();
        sender_gaps = 1'b0;
        write_pane_limit(CFG_W'(2));
        send_word(32'hA5A5_0002, 16'h1234);
        send_word(32'hA5A5_0003, 16'h4321);
        write_pane_limit(CFG_W'(1));
        for (int i = 0; i < PUMP_WORDS; i++)
            send_word(32'hA5A5_0001, AMOUNT_MAX);
        write_pane_limit(CFG_W'(2));
        sender_gaps = 1'b1;
        send_word(32'hA5A5_0001, 16'h0001);
        send_word(32'hA5A5_0001, '0);
    endtask

    // Bursts under random ring sizes. Stamps mostly come from a narrow band
    // around a per-burst base so panes hit often; the rest are wild values,
    // the two extremes and stamps drawn from any ring pane, hidden ones included.
    task automatic test_random_traffic();
        int unsigned        target;
        int unsigned        burst;
        int unsigned        n;
        int unsigned        pick;
        logic [STAMP_W-1:0] base;
        logic [STAMP_W-1:0] stamp;
        logic [AMOUNT_W-1:0] amt;
        logic [CFG_W-1:0]   limit;
        target = words_sent + RANDOM_WORDS;
        while (words_sent < target) begin
            case ($urandom_range(0, 9))
                0:       limit = '0;
                1:       limit = CFG_W'($urandom_range(MAX_PANES + 1, 31));
                2:       limit = CFG_W'(MAX_PANES);
                3:       limit = CFG_W'(1);
                default: limit = CFG_W'($urandom_range(1, MAX_PANES));
            endcase
            write_pane_limit(limit);
            sender_gaps = ($urandom_range(0, 3) != 0);
            base  = $urandom;
            n     = live_panes();
            burst = $urandom_range(20, 80);
            for (int k = 0; k < burst; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    stamp = base + $urandom_range(0, 2 * n + 1);
                else if (pick < 80)
                    stamp = $urandom;
                else if (pick < 85)
                    stamp = '0;
                else if (pick < 90)
                    stamp = STAMP_MAX;
                else
                    stamp = ring_stamp[$urandom_range(0, MAX_PANES - 1)];
                pick = $urandom_range(0, 99);
                if (pick < 10)
                    amt = '0;
                else if (pick < 20)
                    amt = AMOUNT_MAX;
                else
                    amt = AMOUNT_W'($urandom_range(0, 65535));
                send_word(stamp, amt);
                // now and then let the block run dry mid-burst
                if ($urandom_range(0, 39) == 0)
                    wait_idle();
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------

    initial begin
        clear_ring();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_panes();
        test_ring_wrap();
        test_ring_shrink();
        test_register_limits();
        test_count_saturation();
        test_random_traffic();

        wait_idle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        fail_count += totals_due.size();
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
